// ===== src/assert_macros.svh =====
// Assertion macros used by rtd_ctrl.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, sampled on clk_i, disabled while in reset.
`define RTD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// At most one bit of a vector or packed struct is set.
`define RTD_ASSERT_ONEHOT0(label, sig, msg) \
  `RTD_ASSERT(label, $onehot0(sig), msg)

`endif

// ===== src/rtd_pkg.sv =====
// Package for the RTD code to temperature block: field widths, register
// indexes, reset values and the controller/datapath command and status types.
// No dependencies.
package rtd_pkg;

  localparam int CMD_W      = 1;
  localparam int IDX_W      = 10;
  localparam int RES_W      = 20;
  localparam int BYTE_W     = 8;
  localparam int CODE_W     = 15;
  localparam int RATIO_W    = 32;
  localparam int CELSIUS_W  = 11;
  localparam int TEMP_W     = 18;
  localparam int FRAC_BITS  = 24;
  localparam int PROD1_W    = CODE_W + RATIO_W;
  localparam int PROD2_W    = PROD1_W + 7;
  localparam int DVD_W      = RES_W + 7;
  localparam int QUO_W      = 7;
  localparam int DIV_STEPS  = QUO_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_SCALE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_INDEX      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_CELSIUS = 2'd2;

  localparam logic [RATIO_W-1:0]          RATIO_RESET   = 32'd2201600;
  localparam logic [IDX_W-1:0]            TOP_RESET     = 10'd1023;
  localparam logic signed [CELSIUS_W-1:0] LOWEST_RESET  = 11'sd0;

  localparam logic [0:0] CMD_LOAD    = 1'b0;
  localparam logic [0:0] CMD_CONVERT = 1'b1;

  localparam logic [RES_W-1:0]         RES_MAX   = 20'hFFFFF;
  localparam logic [FRAC_BITS-1:0]     RND_ADD   = '1;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX  = 18'sh1FFFF;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN  = -18'sh20000;
  localparam logic [6:0]               CENTI     = 7'd100;
  localparam logic [QUO_W-1:0]         FRAC_CAP  = 7'd99;

  typedef struct packed {
    logic capture;
    logic mul1;
    logic mul2;
    logic round;
    logic search_cmp;
    logic up_cap;
    logic lo_rd;
    logic lo_cap;
    logic div_prep;
    logic div_step;
    logic temp_calc;
    logic out_load;
  } rtd_cmd_t;

  typedef struct packed {
    logic search_open;
    logic cmp_hit;
    logic cmp_more;
    logic interp;
  } rtd_status_t;

endpackage

// ===== src/rtd_if.sv =====
// Request and result channel interfaces of the RTD code to temperature block.
// Depends on rtd_pkg for field widths.
interface rtd_in_if;
  import rtd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [IDX_W-1:0]  entry_index;
  logic [RES_W-1:0]  entry_value;
  logic [BYTE_W-1:0] high_byte;
  logic [BYTE_W-1:0] low_byte;

  modport source (output valid, command, entry_index, entry_value, high_byte, low_byte,
                  input ready);
  modport sink   (input valid, command, entry_index, entry_value, high_byte, low_byte,
                  output ready);
endinterface

interface rtd_out_if;
  import rtd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic [RES_W-1:0]         resistance_centi;
  logic                     out_of_range;
  logic                     load_done;

  modport source (output valid, temperature_centi, resistance_centi, out_of_range, load_done,
                  input ready);
  modport sink   (input valid, temperature_centi, resistance_centi, out_of_range, load_done,
                  output ready);
endinterface

// ===== src/rtd_cfg_regs.sv =====
// Configuration registers: ratio scale, top table index, lowest temperature.
// Depends on rtd_pkg.
module rtd_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rtd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [rtd_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output logic [rtd_pkg::RATIO_W-1:0]          ratio_scale_o,
  output logic [rtd_pkg::IDX_W-1:0]            top_index_o,
  output logic signed [rtd_pkg::CELSIUS_W-1:0] lowest_celsius_o
);
  import rtd_pkg::*;

  logic [RATIO_W-1:0]          ratio_q;
  logic [IDX_W-1:0]            top_q;
  logic signed [CELSIUS_W-1:0] lowest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q  <= RATIO_RESET;
      top_q    <= TOP_RESET;
      lowest_q <= LOWEST_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RATIO_SCALE:    ratio_q  <= cfg_data_i[RATIO_W-1:0];
        CFG_TOP_INDEX:      top_q    <= cfg_data_i[IDX_W-1:0];
        CFG_LOWEST_CELSIUS: lowest_q <= $signed(cfg_data_i[CELSIUS_W-1:0]);
        default: ;
      endcase
    end
  end

  assign ratio_scale_o    = ratio_q;
  assign top_index_o      = top_q;
  assign lowest_celsius_o = lowest_q;

endmodule

// ===== src/rtd_ctrl.sv =====
// Controller state machine: sequences product, search, division and result.
// Depends on rtd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rtd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_command_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  rtd_pkg::rtd_status_t status_i,
  output rtd_pkg::rtd_cmd_t    cmd_o
);
  import rtd_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL1  = 4'd1;
  localparam logic [3:0] S_MUL2  = 4'd2;
  localparam logic [3:0] S_RND   = 4'd3;
  localparam logic [3:0] S_SRD   = 4'd4;
  localparam logic [3:0] S_SCMP  = 4'd5;
  localparam logic [3:0] S_UPRD  = 4'd6;
  localparam logic [3:0] S_UPCAP = 4'd7;
  localparam logic [3:0] S_LORD  = 4'd8;
  localparam logic [3:0] S_LOCAP = 4'd9;
  localparam logic [3:0] S_DPREP = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_TEMP  = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  localparam logic [2:0] DIV_LAST = 3'(DIV_STEPS - 1);

  logic [3:0] state_q, state_d;
  logic [2:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (in_command_i == CMD_LOAD) ? S_FIN : S_MUL1;
        end
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = S_RND;
      end
      S_RND: begin
        cmd_o.round = 1'b1;
        state_d = status_i.search_open ? S_SRD : S_UPRD;
      end
      S_SRD: begin
        state_d = S_SCMP;
      end
      S_SCMP: begin
        cmd_o.search_cmp = 1'b1;
        if (status_i.cmp_hit || !status_i.cmp_more) begin
          state_d = S_UPRD;
        end else begin
          state_d = S_SRD;
        end
      end
      S_UPRD: begin
        state_d = S_UPCAP;
      end
      S_UPCAP: begin
        cmd_o.up_cap = 1'b1;
        state_d = S_LORD;
      end
      S_LORD: begin
        cmd_o.lo_rd = 1'b1;
        state_d = status_i.interp ? S_LOCAP : S_TEMP;
      end
      S_LOCAP: begin
        cmd_o.lo_cap = 1'b1;
        state_d = S_DPREP;
      end
      S_DPREP: begin
        cmd_o.div_prep = 1'b1;
        step_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 3'd1;
        if (step_q == DIV_LAST) begin
          state_d = S_TEMP;
        end
      end
      S_TEMP: begin
        cmd_o.temp_calc = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `RTD_ASSERT(a_accept_leaves_idle, (in_valid_i && in_ready_o) |=> (state_q != S_IDLE), "accepted request left the controller idle")
  `RTD_ASSERT(a_load_only_when_free, cmd_o.out_load |-> (!out_valid_q || out_ready_i), "result overwritten before it was taken")
  `RTD_ASSERT_ONEHOT0(a_cmd_onehot0, cmd_o, "more than one datapath command in a cycle")

endmodule

// ===== src/rtd_datapath.sv =====
// Datapath: resistance table memory, resistance product, search registers,
// restoring divider and temperature assembly. Depends on rtd_pkg.
module rtd_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  rtd_pkg::rtd_cmd_t                    cmd_i,
  output rtd_pkg::rtd_status_t                 status_o,
  input  logic [rtd_pkg::CMD_W-1:0]            command_i,
  input  logic [rtd_pkg::IDX_W-1:0]            entry_index_i,
  input  logic [rtd_pkg::RES_W-1:0]            entry_value_i,
  input  logic [rtd_pkg::BYTE_W-1:0]           high_byte_i,
  input  logic [rtd_pkg::BYTE_W-1:0]           low_byte_i,
  input  logic [rtd_pkg::RATIO_W-1:0]          ratio_scale_i,
  input  logic [rtd_pkg::IDX_W-1:0]            top_index_i,
  input  logic signed [rtd_pkg::CELSIUS_W-1:0] lowest_celsius_i,
  output logic signed [rtd_pkg::TEMP_W-1:0]    temperature_centi_o,
  output logic [rtd_pkg::RES_W-1:0]            resistance_centi_o,
  output logic                                 out_of_range_o,
  output logic                                 load_done_o
);
  import rtd_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = (AW > IDX_W) ? AW + 1 : IDX_W + 1;
  localparam logic [IW-1:0] DEPTH_LIM = IW'(TABLE_DEPTH);

  logic [RES_W-1:0] mem_q [TABLE_DEPTH];

  logic                 load_q;
  logic [CODE_W-1:0]    code_q;
  logic [PROD1_W-1:0]   prod1_q;
  logic [PROD2_W-1:0]   prod2_q;
  logic [RES_W-1:0]     r_q, r_d;
  logic [IDX_W-1:0]     lo_q, hi_q, mid_q;
  logic [IDX_W-1:0]     lo_n, hi_n, mid_n;
  logic [RES_W-1:0]     rdata_q, rd_val, up_q;
  logic                 rzero_q;
  logic [RES_W-1:0]     num_q, den_q, rem_q;
  logic [QUO_W-1:0]     dbits_q, quo_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic                 oor_q;

  logic [IDX_W-1:0]     rd_idx;
  logic [IW-1:0]        rd_ext, wr_ext;
  logic                 wr_en;
  logic [PROD2_W:0]     rsum;
  logic [PROD2_W-FRAC_BITS:0] rshift;
  logic [DVD_W-1:0]     dvd;
  logic [RES_W:0]       trial, trial_sub;
  logic                 at_zero, above, interp;
  logic [IDX_W-1:0]     sel_idx;
  logic signed [12:0]   base;
  logic signed [19:0]   scaled;
  logic signed [20:0]   tsum;
  logic [QUO_W-1:0]     frac;
  logic [IDX_W:0]       lo_plus, mid_sum;

  // table write on load request, registered read every cycle
  assign wr_en  = cmd_i.capture && (command_i == CMD_LOAD);
  assign wr_ext = IW'(entry_index_i);
  assign rd_idx = cmd_i.lo_rd ? (mid_q - 10'd1) : mid_q;
  assign rd_ext = IW'(rd_idx);

  always_ff @(posedge clk_i) begin
    if (wr_en && (wr_ext < DEPTH_LIM)) begin
      mem_q[wr_ext[AW-1:0]] <= entry_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[rd_ext[AW-1:0]];
    rzero_q <= !(rd_ext < DEPTH_LIM);
  end

  assign rd_val = rzero_q ? '0 : rdata_q;

  // rounding up to hundredths and saturation
  always_comb begin
    rsum   = {1'b0, prod2_q} + (PROD2_W + 1)'(RND_ADD);
    rshift = rsum[PROD2_W:FRAC_BITS];
    r_d    = (rshift > (PROD2_W - FRAC_BITS + 1)'(RES_MAX)) ? RES_MAX : rshift[RES_W-1:0];
  end

  // binary search step
  always_comb begin
    lo_n    = lo_q;
    hi_n    = hi_q;
    lo_plus = {1'b0, mid_q} + 11'd1;
    if (rd_val < r_q) begin
      lo_n = lo_plus[IDX_W-1:0];
    end else begin
      hi_n = mid_q;
    end
    mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
    mid_n   = mid_sum[IDX_W:1];
  end

  assign at_zero = (mid_q == '0);
  assign above   = !at_zero && (r_q > up_q);
  assign interp  = !at_zero && (r_q < up_q);

  assign status_o.search_open = (top_index_i != '0);
  assign status_o.cmp_hit     = (rd_val == r_q);
  assign status_o.cmp_more    = (lo_n < hi_n);
  assign status_o.interp      = interp;

  // restoring divider, one quotient bit per step
  assign dvd       = DVD_W'(num_q) * DVD_W'(CENTI);
  assign trial     = {rem_q, dbits_q[QUO_W-1]};
  assign trial_sub = trial - {1'b0, den_q};

  // temperature assembly
  always_comb begin
    sel_idx = above ? top_index_i : mid_q;
    base    = 13'(lowest_celsius_i) + $signed({3'b000, sel_idx}) - (interp ? 13'sd1 : 13'sd0);
    scaled  = $signed({{7{base[12]}}, base}) * 20'sd100;
    if (!interp || (den_q == '0)) begin
      frac = '0;
    end else begin
      frac = (quo_q > FRAC_CAP) ? FRAC_CAP : quo_q;
    end
    tsum = $signed({scaled[19], scaled}) + $signed({14'b0, frac});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      load_q <= (command_i == CMD_LOAD);
      code_q <= {high_byte_i, low_byte_i[BYTE_W-1:1]};
    end
    if (cmd_i.mul1) begin
      prod1_q <= PROD1_W'(code_q) * PROD1_W'(ratio_scale_i);
    end
    if (cmd_i.mul2) begin
      prod2_q <= PROD2_W'(prod1_q) * PROD2_W'(CENTI);
    end
    if (cmd_i.round) begin
      r_q   <= r_d;
      lo_q  <= '0;
      hi_q  <= top_index_i;
      mid_q <= top_index_i >> 1;
    end
    if (cmd_i.search_cmp && !status_o.cmp_hit) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      mid_q <= mid_n;
    end
    if (cmd_i.up_cap) begin
      up_q <= rd_val;
    end
    if (cmd_i.lo_cap) begin
      num_q <= (r_q > rd_val) ? (r_q - rd_val) : '0;
      den_q <= (up_q > rd_val) ? (up_q - rd_val) : '0;
    end
    if (cmd_i.div_prep) begin
      rem_q   <= dvd[DVD_W-1:QUO_W];
      dbits_q <= dvd[QUO_W-1:0];
      quo_q   <= '0;
    end
    if (cmd_i.div_step) begin
      if (!trial_sub[RES_W]) begin
        rem_q <= trial_sub[RES_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[RES_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
      dbits_q <= {dbits_q[QUO_W-2:0], 1'b0};
    end
    if (cmd_i.temp_calc) begin
      oor_q <= at_zero || above;
      if (tsum > TEMP_MAX) begin
        temp_q <= TEMP_MAX;
      end else if (tsum < TEMP_MIN) begin
        temp_q <= TEMP_MIN;
      end else begin
        temp_q <= tsum[TEMP_W-1:0];
      end
    end
    if (cmd_i.out_load) begin
      load_done_o <= load_q;
      if (load_q) begin
        temperature_centi_o <= '0;
        resistance_centi_o  <= '0;
        out_of_range_o      <= 1'b0;
      end else begin
        temperature_centi_o <= temp_q;
        resistance_centi_o  <= r_q;
        out_of_range_o      <= oor_q;
      end
    end
  end

endmodule

// ===== src/rtd_code_to_temperature.sv =====
// Top level of the RTD code to temperature block: configuration registers,
// controller and datapath. Depends on rtd_pkg, rtd_if, rtd_cfg_regs, rtd_ctrl, rtd_datapath.
//
// Load the resistance table first with load requests (command 0), one entry in hundredths of
// an ohm per degree; the table holds no defined values until loaded. A convert request
// (command 1) takes the two converter bytes, forms the resistance, binary searches the table
// and interpolates to hundredths of a degree. One request is in flight at a time; the result
// sits in an output register, so the next request is taken while it waits. A load goes from
// acceptance straight to the result state, which loads the output register once it is free.
// The search takes at most ceil(log2(top_index + 1)) steps, ten for a full table; each step
// has a read state and a compare state for the registered table read, and the interpolation
// adds a seven-step restoring division. Write configuration only while idle.
module rtd_code_to_temperature #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rtd_in_if.sink                         in_i,
  rtd_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [rtd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rtd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rtd_pkg::*;

  logic [RATIO_W-1:0]          ratio_scale;
  logic [IDX_W-1:0]            top_index;
  logic signed [CELSIUS_W-1:0] lowest_celsius;
  rtd_cmd_t                    cmd;
  rtd_status_t                 status;

  rtd_cfg_regs u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .ratio_scale_o    (ratio_scale),
    .top_index_o      (top_index),
    .lowest_celsius_o (lowest_celsius)
  );

  rtd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  rtd_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i               (clk_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .command_i           (in_i.command),
    .entry_index_i       (in_i.entry_index),
    .entry_value_i       (in_i.entry_value),
    .high_byte_i         (in_i.high_byte),
    .low_byte_i          (in_i.low_byte),
    .ratio_scale_i       (ratio_scale),
    .top_index_i         (top_index),
    .lowest_celsius_i    (lowest_celsius),
    .temperature_centi_o (out_o.temperature_centi),
    .resistance_centi_o  (out_o.resistance_centi),
    .out_of_range_o      (out_o.out_of_range),
    .load_done_o         (out_o.load_done)
  );

endmodule
